// ===== design/ffa_pkg.sv =====
package ffa_pkg;
  localparam int MaxSegments = 64;
  localparam int IdxW = $clog2(MaxSegments);
  localparam int CntW = $clog2(MaxSegments + 1);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_NOOWNER = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // one table entry: free flag, owner, start, size
  typedef struct packed {
    logic        free;
    logic [7:0]  owner;
    logic [15:0] start;
    logic [15:0] size;
  } seg_t;
endpackage

// ===== design/ffa_table.sv =====
// segment table memory: one write port, one registered read port
module ffa_table (
  input  logic                    clk,
  input  logic                    we,
  input  logic [ffa_pkg::IdxW-1:0] waddr,
  input  ffa_pkg::seg_t           wdata,
  input  logic [ffa_pkg::IdxW-1:0] raddr,
  output ffa_pkg::seg_t           rdata
);
  import ffa_pkg::*;

  seg_t mem [MaxSegments];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/first_fit_heap_allocator_top.sv =====
// a scan reads table entries in order; a split or merge then shifts the
//   table entries after it, one entry at a time
// throughput: one request at a time; in_stall stays high from accept until the
//   result is taken; the rate is set by the walk through the table memory
// reset: table holds one free segment of 4096 units; no clearing pass is needed
//   since only entries below the fill count are read
module first_fit_heap_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_heap_size,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_owner_id,
  input  logic [15:0] in_alloc_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_start_index
);
  import ffa_pkg::*;

  // sequencer states
  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SCAN_A = 10'b0000000010, // address entry i
    S_SCAN_D = 10'b0000000100, // read data valid, test it
    S_SHUP_A = 10'b0000001000, // shift up: read k-1
    S_SHUP_D = 10'b0000010000, // write k
    S_SPLIT  = 10'b0000100000, // write split pair
    S_NXT_A  = 10'b0001000000, // free: read i+1
    S_NXT_D  = 10'b0010000000,
    S_SHDN   = 10'b0100000000, // shift down loop (read k+n, write k)
    S_DONE   = 10'b1000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic [CntW-1:0]   idx_r, idx_nxt;     // found entry / scan index
  logic [CntW-1:0]   k_r, k_nxt;         // shift index
  logic              act_r, act_nxt;
  logic [7:0]        id_r, id_nxt;
  logic [15:0]       size_r, size_nxt;
  seg_t              cur_r, cur_nxt;     // found entry copy
  seg_t              prev_r, prev_nxt;   // entry before scan position
  logic              split_r, split_nxt; // split pending second write
  logic              shpend_r, shpend_nxt; // shift-down read pending
  logic              mrg_prev_r, mrg_prev_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [15:0]       start_r, start_nxt;
  logic              ov_r, ov_nxt;
  logic [15:0]       heap_r;

  // reset loads table entry 0 through the table write port, held while reset is active and while init_r is set
  logic              init_r;
  seg_t              rst_seg;

  logic              we;
  logic [IdxW-1:0]   waddr, raddr;
  seg_t              wdata, rdata, init_seg;

  ffa_table u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall        = (state_r != S_IDLE) || ov_r;
  assign out_valid       = ov_r;
  assign out_status      = status_r;
  assign out_start_index = start_r;

  always_comb begin
    init_seg       = '0;
    init_seg.free  = 1'b1;
    init_seg.size  = cfg_heap_size;
  end

  always_comb begin
    rst_seg      = '0;
    rst_seg.free = 1'b1;
    rst_seg.size = heap_r;
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    k_nxt        = k_r;
    act_nxt      = act_r;
    id_nxt       = id_r;
    size_nxt     = size_r;
    cur_nxt      = cur_r;
    prev_nxt     = prev_r;
    split_nxt    = split_r;
    shpend_nxt   = shpend_r;
    mrg_prev_nxt = mrg_prev_r;
    status_nxt   = status_r;
    start_nxt    = start_r;
    ov_nxt       = ov_r;
    we           = 1'b0;
    waddr        = idx_r[IdxW-1:0];
    wdata        = cur_r;
    raddr        = idx_r[IdxW-1:0];

    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          // rewrite table to a single free segment
          we        = 1'b1;
          waddr     = '0;
          wdata     = init_seg;
          count_nxt = CntW'(1);
        end else if (in_valid && !in_stall) begin
          act_nxt  = in_action;
          id_nxt   = in_owner_id;
          size_nxt = in_alloc_size;
          idx_nxt  = '0;
          prev_nxt = '0;
          if (in_action == ACT_ALLOC && in_alloc_size == 16'd0) begin
            status_nxt = ST_NOFIT;
            start_nxt  = '0;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_SCAN_A;
          end
        end
      end

      S_SCAN_A: begin
        if (idx_r >= count_r) begin
          status_nxt = (act_r == ACT_ALLOC) ? ST_NOFIT : ST_NOOWNER;
          start_nxt  = '0;
          state_nxt  = S_DONE;
        end else begin
          raddr     = idx_r[IdxW-1:0];
          state_nxt = S_SCAN_D;
        end
      end

      S_SCAN_D: begin
        cur_nxt = rdata;
        if (act_r == ACT_ALLOC) begin
          if (rdata.free && rdata.size >= size_r) begin
            start_nxt = rdata.start;
            if (size_r < rdata.size) begin
              if (count_r >= CntW'(MaxSegments)) begin
                status_nxt = ST_FULL;
                start_nxt  = '0;
                state_nxt  = S_DONE;
              end else begin
                status_nxt = ST_OK;
                k_nxt      = count_r;
                state_nxt  = S_SHUP_A;
              end
            end else begin
              // exact fit: hand over whole
              we         = 1'b1;
              wdata      = rdata;
              wdata.free = 1'b0;
              wdata.owner = id_r;
              status_nxt = ST_OK;
              state_nxt  = S_DONE;
            end
          end else begin
            idx_nxt   = idx_r + CntW'(1);
            state_nxt = S_SCAN_A;
          end
        end else begin
          if (!rdata.free && rdata.owner == id_r) begin
            status_nxt   = ST_OK;
            start_nxt    = '0;
            cur_nxt.free = 1'b1;
            mrg_prev_nxt = (idx_r != '0) && prev_r.free;
            state_nxt    = S_NXT_A;
          end else begin
            prev_nxt  = rdata;
            idx_nxt   = idx_r + CntW'(1);
            state_nxt = S_SCAN_A;
          end
        end
      end

      S_SHUP_A: begin
        if (k_r > idx_r + CntW'(1)) begin
          raddr     = IdxW'(k_r - CntW'(1));
          state_nxt = S_SHUP_D;
        end else begin
          state_nxt = S_SPLIT;
          split_nxt = 1'b0;
        end
      end

      S_SHUP_D: begin
        we        = 1'b1;
        waddr     = k_r[IdxW-1:0];
        wdata     = rdata;
        k_nxt     = k_r - CntW'(1);
        state_nxt = S_SHUP_A;
      end

      S_SPLIT: begin
        we = 1'b1;
        if (!split_r) begin
          waddr       = IdxW'(idx_r + CntW'(1));
          wdata.free  = 1'b1;
          wdata.owner = '0;
          wdata.start = cur_r.start + size_r;
          wdata.size  = cur_r.size - size_r;
          split_nxt   = 1'b1;
        end else begin
          waddr       = idx_r[IdxW-1:0];
          wdata       = cur_r;
          wdata.free  = 1'b0;
          wdata.owner = id_r;
          wdata.size  = size_r;
          count_nxt   = count_r + CntW'(1);
          split_nxt   = 1'b0;
          state_nxt   = S_DONE;
        end
      end

      S_NXT_A: begin
        if (idx_r + CntW'(1) < count_r) begin
          raddr     = IdxW'(idx_r + CntW'(1));
          state_nxt = S_NXT_D;
        end else begin
          state_nxt = S_NXT_D;
          cur_nxt   = cur_r;
        end
      end

      S_NXT_D: begin
        if (idx_r + CntW'(1) < count_r && rdata.free) begin
          cur_nxt.size = cur_r.size + rdata.size;
          if (mrg_prev_r) begin
            // predecessor absorbs both, remove i and i+1
            prev_nxt.size = prev_r.size + cur_r.size + rdata.size;
            we            = 1'b1;
            waddr         = IdxW'(idx_r - CntW'(1));
            wdata         = prev_r;
            wdata.size    = prev_r.size + cur_r.size + rdata.size;
            k_nxt         = idx_r;
            size_nxt      = 16'd2; // entries to remove
          end else begin
            we         = 1'b1;
            wdata      = cur_r;
            wdata.size = cur_r.size + rdata.size;
            k_nxt      = idx_r + CntW'(1);
            size_nxt   = 16'd1;
          end
          shpend_nxt = 1'b0;
          state_nxt  = S_SHDN;
        end else if (mrg_prev_r) begin
          we         = 1'b1;
          waddr      = IdxW'(idx_r - CntW'(1));
          wdata      = prev_r;
          wdata.size = prev_r.size + cur_r.size;
          k_nxt      = idx_r;
          size_nxt   = 16'd1;
          shpend_nxt = 1'b0;
          state_nxt  = S_SHDN;
        end else begin
          we        = 1'b1;
          wdata     = cur_r;
          state_nxt = S_DONE;
        end
      end

      S_SHDN: begin
        // move entry k+n to k for k below count-n, n = size_r (1 or 2)
        if (!shpend_r) begin
          if (k_r + CntW'(size_r) < count_r) begin
            raddr      = IdxW'(k_r + CntW'(size_r));
            shpend_nxt = 1'b1;
          end else begin
            count_nxt = count_r - CntW'(size_r);
            state_nxt = S_DONE;
          end
        end else begin
          we         = 1'b1;
          waddr      = k_r[IdxW-1:0];
          wdata      = rdata;
          k_nxt      = k_r + CntW'(1);
          shpend_nxt = 1'b0;
        end
      end

      S_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // entry 0 gets the default heap during reset and the first cycle after,
    // unless a heap size write takes that slot
    if (!rst_n || (init_r && !cfg_we)) begin
      we    = 1'b1;
      waddr = '0;
      wdata = rst_seg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= CntW'(1);
      ov_r       <= 1'b0;
      split_r    <= 1'b0;
      shpend_r   <= 1'b0;
      heap_r     <= 16'd4096;
      init_r     <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      ov_r       <= ov_nxt;
      split_r    <= split_nxt;
      shpend_r   <= shpend_nxt;
      init_r     <= 1'b0;
      if (cfg_we) begin
        heap_r <= cfg_heap_size;
      end
    end
    idx_r      <= idx_nxt;
    k_r        <= k_nxt;
    act_r      <= act_nxt;
    id_r       <= id_nxt;
    size_r     <= size_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    mrg_prev_r <= mrg_prev_nxt;
    status_r   <= status_nxt;
    start_r    <= start_nxt;
  end

endmodule

// ===== verif/ffa_checker.sv =====
`timescale 1ns / 100ps

module ffa_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_heap_size,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_owner_id,
  input  logic [15:0] in_alloc_size,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [15:0] out_start_index,
  output int          fail_count,
  output int          pending
);
  import ffa_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] start;
  } grant_t;

  seg_t   heap_tbl [MaxSegments];
  int     heap_cnt;
  grant_t grant_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic heap_init(input logic [15:0] hsize);
    for (int k = 0; k < MaxSegments; k++) heap_tbl[k] = '0;
    heap_tbl[0].free = 1'b1;
    heap_tbl[0].size = hsize;
    heap_cnt = 1;
  endtask

  task automatic drop_seg(input int pos);
    for (int k = pos; k + 1 < heap_cnt; k++) heap_tbl[k] = heap_tbl[k+1];
    heap_cnt--;
  endtask

  // first-fit allocate or release by owner, updates the shadow table
  task automatic heap_predict(input logic act, input logic [7:0] id,
                              input logic [15:0] sz, output grant_t g);
    int i;
    g = '0;
    if (act == ACT_ALLOC) begin
      g.status = ST_NOFIT;
      if (sz == 0) return;
      for (i = 0; i < heap_cnt; i++)
        if (heap_tbl[i].free && heap_tbl[i].size >= sz) break;
      if (i >= heap_cnt) return;
      if (sz < heap_tbl[i].size) begin
        if (heap_cnt >= MaxSegments) begin
          g.status = ST_FULL;
          return;
        end
        for (int k = heap_cnt; k > i + 1; k--) heap_tbl[k] = heap_tbl[k-1];
        heap_tbl[i+1].free  = 1'b1;
        heap_tbl[i+1].owner = '0;
        heap_tbl[i+1].size  = heap_tbl[i].size - sz;
        heap_tbl[i+1].start = heap_tbl[i].start + sz;
        heap_tbl[i].size    = sz;
        heap_cnt++;
      end
      heap_tbl[i].free  = 1'b0;
      heap_tbl[i].owner = id;
      g.status = ST_OK;
      g.start  = heap_tbl[i].start;
    end else begin
      for (i = 0; i < heap_cnt; i++)
        if (!heap_tbl[i].free && heap_tbl[i].owner == id) break;
      if (i >= heap_cnt) begin
        g.status = ST_NOOWNER;
        return;
      end
      heap_tbl[i].free  = 1'b1;
      heap_tbl[i].owner = '0;
      if (i + 1 < heap_cnt && heap_tbl[i+1].free) begin
        heap_tbl[i].size = heap_tbl[i].size + heap_tbl[i+1].size;
        drop_seg(i + 1);
      end
      if (i > 0 && heap_tbl[i-1].free) begin
        heap_tbl[i-1].size = heap_tbl[i-1].size + heap_tbl[i].size;
        drop_seg(i);
      end
      g.status = ST_OK;
    end
  endtask

  always @(posedge clk) begin
    grant_t g;
    if (!rst_n) begin
      heap_init(16'd4096);
      grant_q.delete();
    end else begin
      if (cfg_we) heap_init(cfg_heap_size);
      if (in_valid && !in_stall) begin
        heap_predict(in_action, in_owner_id, in_alloc_size, g);
        grant_q.push_back(g);
      end
      if (out_valid && !out_stall) begin
        if (grant_q.size() == 0) begin
          $error("unexpected result status %0d start %0d", out_status, out_start_index);
          fail_count++;
        end else begin
          g = grant_q.pop_front();
          if (out_status !== g.status) begin
            $error("status expected %0d actual %0d", g.status, out_status);
            fail_count++;
          end
          if (out_start_index !== g.start) begin
            $error("start_index expected %0d actual %0d", g.start, out_start_index);
            fail_count++;
          end
        end
      end
    end
    pending = grant_q.size();
  end

endmodule

// ===== verif/tb_first_fit_heap_allocator_top.sv =====
`timescale 1ns / 100ps

module tb_first_fit_heap_allocator_top;
  import ffa_pkg::*;

  localparam int DrainCycles = 400;    // worst scan plus table shift
  localparam int StallLimit  = 20000;  // cycles with no request or result moving

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_heap_size = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = ACT_ALLOC;
  logic [7:0]  in_owner_id = '0;
  logic [15:0] in_alloc_size = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_start_index;

  int fail_count;
  int pending;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int quiet_cycles = 0;
  logic [15:0] cur_heap = 16'd4096;
  logic [7:0]  live_ids[$];

  always #2 clk = ~clk;

  first_fit_heap_allocator_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_heap_size(cfg_heap_size),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_owner_id(in_owner_id), .in_alloc_size(in_alloc_size),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_start_index(out_start_index)
  );

  ffa_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_heap_size(cfg_heap_size),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_owner_id(in_owner_id), .in_alloc_size(in_alloc_size),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_start_index(out_start_index),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk)
    out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      quiet_cycles <= 0;
    else if (quiet_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // present one request, hold it until accepted
  task automatic send_req(input logic act, input logic [7:0] id, input logic [15:0] sz);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_action     = act;
    in_owner_id   = id;
    in_alloc_size = sz;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // wait for all results, let the block settle, then rewrite the heap size
  task automatic set_heap(input logic [15:0] hsize);
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    cfg_we        = 1'b1;
    cfg_heap_size = hsize;
    @(negedge clk);
    cfg_we   = 1'b0;
    cur_heap = hsize;
    live_ids.delete();
  endtask

  // allocate with a tracked owner so later frees tend to hit
  task automatic alloc_tracked(input logic [15:0] sz);
    logic [7:0] id;
    if (live_ids.size() > 0 && $urandom_range(0, 3) == 0)
      id = live_ids[$urandom_range(0, live_ids.size() - 1)];
    else
      id = 8'($urandom_range(0, 255));
    live_ids.push_back(id);
    send_req(ACT_ALLOC, id, sz);
  endtask

  task automatic free_tracked();
    int pick;
    logic [7:0] id;
    if (live_ids.size() == 0) begin
      send_req(ACT_FREE, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      return;
    end
    pick = $urandom_range(0, live_ids.size() - 1);
    id = live_ids[pick];
    live_ids.delete(pick);
    send_req(ACT_FREE, id, 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    int hmax;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reset heap of 4096
    send_req(ACT_ALLOC, 8'h01, 16'd0);       // zero-size request
    send_req(ACT_ALLOC, 8'h01, 16'hFFFF);    // too big
    send_req(ACT_ALLOC, 8'h00, 16'd1);       // split
    send_req(ACT_ALLOC, 8'hFF, 16'd4095);    // exact fit of remainder
    send_req(ACT_ALLOC, 8'h02, 16'd1);       // nothing free
    send_req(ACT_FREE,  8'h07, 16'hFFFF);    // unknown owner
    send_req(ACT_FREE,  8'h00, 16'd0);       // successor still owned
    send_req(ACT_FREE,  8'hFF, 16'd0);       // merge with free predecessor
    send_req(ACT_ALLOC, 8'hAA, 16'd4096);    // whole heap
    send_req(ACT_FREE,  8'hAA, 16'd0);

    // zero heap size: every allocate fails
    set_heap(16'd0);
    send_req(ACT_ALLOC, 8'h03, 16'd1);
    send_req(ACT_FREE,  8'h03, 16'd0);

    // largest heap
    set_heap(16'hFFFF);
    send_req(ACT_ALLOC, 8'h55, 16'hFFFF);
    send_req(ACT_FREE,  8'h55, 16'd0);

    // smallest heap
    set_heap(16'd1);
    send_req(ACT_ALLOC, 8'h11, 16'd1);
    send_req(ACT_ALLOC, 8'h12, 16'd1);

    // fill the table so a split finds no room, then take the rest exactly
    set_heap(16'd65);
    for (int k = 0; k < 63; k++) send_req(ACT_ALLOC, k[7:0], 16'd1);
    send_req(ACT_ALLOC, 8'hC0, 16'd1);       // table full on split
    send_req(ACT_ALLOC, 8'hC1, 16'd2);       // exact fit still works
    send_req(ACT_FREE,  8'd10, 16'd0);       // free in the middle
    send_req(ACT_FREE,  8'd12, 16'd0);
    send_req(ACT_FREE,  8'd11, 16'd0);       // merge both sides

    // random phases with different idle mixes
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin snd_idle_pct = 7;  rcv_idle_pct = 60; end
        1: begin snd_idle_pct = 60; rcv_idle_pct = 7;  end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      if ($urandom_range(0, 1)) set_heap(16'($urandom_range(40, 400)));
      else set_heap(16'($urandom_range(1, 65535)));
      for (int n = 0; n < 200; n++) begin
        int r;
        r = $urandom_range(0, 99);
        hmax = (cur_heap > 16) ? cur_heap / 16 : 1;
        if (n == 100 && ph == 2) set_heap(16'($urandom_range(50, 120)));
        if (r < 40)      alloc_tracked(16'($urandom_range(1, hmax)));
        else if (r < 70) free_tracked();
        else if (r < 85) send_req(ACT_FREE, 8'($urandom_range(0, 255)),
                                  16'($urandom_range(0, 65535)));
        else if (r < 95) alloc_tracked(16'($urandom_range(0, 65535)));
        else             alloc_tracked(16'($urandom_range(1, 3)));
      end
    end

    // drain and verdict
    snd_idle_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
